// ----- hdl/csh_pkg.sv -----
package csh_pkg;

	// field widths fixed by the interface
	localparam int KIND_W = 2;
	localparam int CODE_W = 16;
	localparam int SEL_W = 10;
	localparam int CFG_W = 11;
	localparam int OUT_W = 32;

	// wide enough for any bin count up to 65536
	localparam int NUM_W = 17;

	localparam int MAX_BINS_DEF = 1024;
	localparam int COUNT_BITS_DEF = 32;
	localparam int MIN_BINS = 4;
	localparam logic [CFG_W-1:0] BIN_COUNT_RST = 11'd1024;

	localparam int QUEUE_DEPTH = 4;

	// input kind codes
	localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	// classified operation handed from front to back
	typedef enum logic [3:0] {
		OP_DROP,
		OP_ADD_CENTER,
		OP_ADD_BELOW,
		OP_ADD_ABOVE,
		OP_ADD_BIN,
		OP_RD_CENTER,
		OP_RD_BELOW,
		OP_RD_ABOVE,
		OP_RD_BIN,
		OP_RD_ZERO,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t op;
		logic [CODE_W-1:0] idx;
		logic [SEL_W-1:0] sel;
	} entry_t;

	typedef enum logic {
		ST_RUN,
		ST_SWEEP
	} back_state_t;

	function automatic logic is_read(op_t op);
		return (op == OP_RD_CENTER) || (op == OP_RD_BELOW) || (op == OP_RD_ABOVE) ||
			(op == OP_RD_BIN) || (op == OP_RD_ZERO);
	endfunction

endpackage

// ----- hdl/csh_ram.sv -----
module csh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/csh_front.sv -----
module csh_front
	import csh_pkg::*;
#(
	parameter int MAX_BINS = MAX_BINS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_W-1:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input logic [KIND_W-1:0] kind,
	input logic [CODE_W-1:0] code_value,
	input logic [SEL_W-1:0] bin_select,
	input logic q_full,
	input logic init_busy,
	output logic push,
	output entry_t push_entry
);

	localparam logic [NUM_W-1:0] MaxN = NUM_W'(MAX_BINS);
	localparam logic [NUM_W-1:0] MinN = NUM_W'(MIN_BINS);

	logic [CFG_W-1:0] bin_count_q;
	logic [NUM_W-1:0] cnt_ext;
	logic [NUM_W-1:0] bins_n;
	logic [NUM_W-1:0] radius;
	logic [NUM_W-1:0] code_ext;
	logic [NUM_W-1:0] sel_ext;

	// bin count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q <= BIN_COUNT_RST;
		end else if (cfg_we) begin
			bin_count_q <= cfg_wdata;
		end
	end

	// clamp the bin count and derive the centre
	always_comb begin
		cnt_ext = NUM_W'(bin_count_q);
		if (cnt_ext < MinN) begin
			bins_n = MinN;
		end else if (cnt_ext > MaxN) begin
			bins_n = MaxN;
		end else begin
			bins_n = cnt_ext;
		end
		radius = bins_n >> 1;
		code_ext = NUM_W'(code_value);
		sel_ext = NUM_W'(bin_select);
	end

	// accept while the queue has room and the reset clear is done; drop unused kinds
	assign in_ready = !q_full && !init_busy;
	assign push = in_valid && in_ready &&
		((kind == KIND_ADD) || (kind == KIND_READ) || (kind == KIND_CLEAR));

	// classify the beat
	always_comb begin
		push_entry.sel = bin_select;
		push_entry.idx = code_value;
		push_entry.op = OP_CLEAR;
		case (kind)
			KIND_ADD: begin
				if (code_ext >= bins_n) begin
					push_entry.op = OP_DROP;
				end else if (code_ext == radius) begin
					push_entry.op = OP_ADD_CENTER;
				end else if (code_ext == radius - NUM_W'(1)) begin
					push_entry.op = OP_ADD_BELOW;
				end else if (code_ext == radius + NUM_W'(1)) begin
					push_entry.op = OP_ADD_ABOVE;
				end else begin
					push_entry.op = OP_ADD_BIN;
				end
			end
			KIND_READ: begin
				push_entry.idx = CODE_W'(bin_select);
				if (sel_ext >= bins_n) begin
					push_entry.op = OP_RD_ZERO;
				end else if (sel_ext == radius) begin
					push_entry.op = OP_RD_CENTER;
				end else if (sel_ext == radius - NUM_W'(1)) begin
					push_entry.op = OP_RD_BELOW;
				end else if (sel_ext == radius + NUM_W'(1)) begin
					push_entry.op = OP_RD_ABOVE;
				end else begin
					push_entry.op = OP_RD_BIN;
				end
			end
			default: begin
				push_entry.op = OP_CLEAR;
			end
		endcase
	end

endmodule

// ----- hdl/csh_queue.sv -----
module csh_queue
	import csh_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	input entry_t push_entry,
	output logic full,
	input logic pop,
	output logic not_empty,
	output entry_t head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LastPtr = PTR_W'(QUEUE_DEPTH - 1);

	entry_t slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head = slot_q[rd_ptr_q];

	// store the entry
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- hdl/csh_back.sv -----
module csh_back
	import csh_pkg::*;
#(
	parameter int MAX_BINS = MAX_BINS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic q_not_empty,
	input entry_t head,
	output logic pop,
	output logic init_busy,
	output logic out_valid,
	input logic out_ready,
	output logic [SEL_W-1:0] bin_number,
	output logic [OUT_W-1:0] bin_total,
	output logic [OUT_W-1:0] dropped_total
);

	localparam int AW = $clog2(MAX_BINS);
	localparam logic [AW-1:0] LastAddr = AW'(MAX_BINS - 1);
	localparam logic [63:0] OutMax = 64'({OUT_W{1'b1}});

	back_state_t state_q, state_d;
	logic init_q;
	logic [AW-1:0] sweep_addr_q;

	logic valid_s1;
	op_t op_s1;
	logic [AW-1:0] addr_s1;
	logic [SEL_W-1:0] sel_s1;

	logic fwd_valid_q;
	logic [AW-1:0] fwd_addr_q;
	logic [COUNT_BITS-1:0] fwd_data_q;

	logic [COUNT_BITS-1:0] below_q, above_q, center_q, dropped_q;

	logic out_valid_q;
	logic [SEL_W-1:0] bin_number_q;
	logic [OUT_W-1:0] bin_total_q;
	logic [OUT_W-1:0] dropped_total_q;

	logic sweeping;
	logic stall_s1;
	logic clear_s1;
	logic read_s1;
	logic out_load;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic [COUNT_BITS-1:0] ram_rdata;
	logic [COUNT_BITS-1:0] cur_bin;
	logic [COUNT_BITS-1:0] total_sel;
	logic [63:0] total_wide;
	logic [63:0] dropped_wide;

	function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] v);
		return (v == '1) ? v : v + COUNT_BITS'(1);
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RUN: begin
				if (valid_s1 && (op_s1 == OP_CLEAR)) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (sweep_addr_q == LastAddr) begin
					state_d = ST_RUN;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	// state outputs
	always_comb begin
		case (state_q)
			ST_SWEEP: sweeping = 1'b1;
			ST_RUN: sweeping = 1'b0;
			default: sweeping = 1'b0;
		endcase
	end

	// stage control
	always_comb begin
		read_s1 = valid_s1 && is_read(op_s1);
		clear_s1 = valid_s1 && (op_s1 == OP_CLEAR);
		stall_s1 = read_s1 && out_valid_q && !out_ready;
		pop = !sweeping && q_not_empty && !stall_s1 && !clear_s1;
		out_load = read_s1 && !stall_s1;
	end

	// bin value seen by stage 1, forwarding the write made as it was read
	assign cur_bin = (fwd_valid_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : ram_rdata;

	// store write: sweep zeroes, otherwise increment a bin
	always_comb begin
		if (sweeping) begin
			ram_we = 1'b1;
			ram_waddr = sweep_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we = valid_s1 && (op_s1 == OP_ADD_BIN);
			ram_waddr = addr_s1;
			ram_wdata = sat_inc(cur_bin);
		end
	end

	csh_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(MAX_BINS)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(pop),
		.raddr(head.idx[AW-1:0]),
		.rdata(ram_rdata)
	);

	// state, sweep address and reset clear flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			init_q <= 1'b1;
			sweep_addr_q <= '0;
		end else begin
			state_q <= state_d;
			if (sweeping) begin
				sweep_addr_q <= (sweep_addr_q == LastAddr) ? '0 : sweep_addr_q + AW'(1);
				if (sweep_addr_q == LastAddr) begin
					init_q <= 1'b0;
				end
			end
		end
	end

	assign init_busy = init_q;

	// stage 1 valid and forwarding control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else if (!stall_s1) begin
			valid_s1 <= pop;
			fwd_valid_q <= ram_we;
		end
	end

	// stage 1 payload and forwarded write
	always_ff @(posedge clk) begin
		if (!stall_s1) begin
			if (pop) begin
				op_s1 <= head.op;
				addr_s1 <= head.idx[AW-1:0];
				sel_s1 <= head.sel;
			end
			fwd_addr_q <= ram_waddr;
			fwd_data_q <= ram_wdata;
		end
	end

	// dedicated counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			below_q <= '0;
			above_q <= '0;
			center_q <= '0;
			dropped_q <= '0;
		end else if (valid_s1) begin
			case (op_s1)
				OP_DROP: dropped_q <= sat_inc(dropped_q);
				OP_ADD_CENTER: center_q <= sat_inc(center_q);
				OP_ADD_BELOW: below_q <= sat_inc(below_q);
				OP_ADD_ABOVE: above_q <= sat_inc(above_q);
				OP_CLEAR: begin
					below_q <= '0;
					above_q <= '0;
					center_q <= '0;
					dropped_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// pick the count for a read
	always_comb begin
		case (op_s1)
			OP_RD_CENTER: total_sel = center_q;
			OP_RD_BELOW: total_sel = below_q;
			OP_RD_ABOVE: total_sel = above_q;
			OP_RD_BIN: total_sel = cur_bin;
			default: total_sel = '0;
		endcase
		total_wide = 64'(total_sel);
		dropped_wide = 64'(dropped_q);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, saturated to the field width
	always_ff @(posedge clk) begin
		if (out_load) begin
			bin_number_q <= sel_s1;
			bin_total_q <= (total_wide > OutMax) ? '1 : total_wide[OUT_W-1:0];
			dropped_total_q <= (dropped_wide > OutMax) ? '1 : dropped_wide[OUT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign bin_number = bin_number_q;
	assign bin_total = bin_total_q;
	assign dropped_total = dropped_total_q;

endmodule

// ----- hdl/centered_sparse_histogram_unit.sv -----
// A read result passes the queue, stage 1 and the output register in turn.
// Throughput: one item per cycle through the single read-modify-write path of the bin
// memory unless a result is held; a clear holds the back end while it is swept to zero.
// Reset: asynchronous, active low; counters zero and bin_count returns to 1024.
// After reset the bin memory is swept to zero with in_ready low.
module centered_sparse_histogram_unit
	import csh_pkg::*;
#(
	parameter int MAX_BINS = MAX_BINS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_W-1:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input logic [KIND_W-1:0] kind,
	input logic [CODE_W-1:0] code_value,
	input logic [SEL_W-1:0] bin_select,
	output logic out_valid,
	input logic out_ready,
	output logic [SEL_W-1:0] bin_number,
	output logic [OUT_W-1:0] bin_total,
	output logic [OUT_W-1:0] dropped_total
);

	logic q_full;
	logic q_not_empty;
	logic push;
	logic pop;
	logic init_busy;
	entry_t push_entry;
	entry_t head;

	csh_front #(
		.MAX_BINS(MAX_BINS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.code_value(code_value),
		.bin_select(bin_select),
		.q_full(q_full),
		.init_busy(init_busy),
		.push(push),
		.push_entry(push_entry)
	);

	csh_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.full(q_full),
		.pop(pop),
		.not_empty(q_not_empty),
		.head(head)
	);

	csh_back #(
		.MAX_BINS(MAX_BINS),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_not_empty(q_not_empty),
		.head(head),
		.pop(pop),
		.init_busy(init_busy),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.bin_number(bin_number),
		.bin_total(bin_total),
		.dropped_total(dropped_total)
	);

endmodule

// ----- test/centered_sparse_histogram_unit_test.sv -----
module centered_sparse_histogram_unit_test;
	import csh_pkg::*;

	// kind 3 has no meaning to the block and must be ignored
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam logic [OUT_W-1:0] COUNT_TOP = {OUT_W{1'b1}};
	localparam int CYCLE_LIMIT = 800000;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 98;
	localparam int NUM_PHASES = 11;
	localparam int QUIET_PHASE = 2;
	localparam int HOLD_PHASE = 4;
	localparam int PAUSE_PHASE = 6;
	localparam int MAX_PRINTS = 50;

	typedef struct {
		logic [SEL_W-1:0] bin;
		logic [OUT_W-1:0] total;
		logic [OUT_W-1:0] dropped;
	} read_beat_t;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [CODE_W-1:0] code;
		logic [SEL_W-1:0] sel;
		bit fixed;
		logic [OUT_W-1:0] total;
		logic [OUT_W-1:0] dropped;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic [KIND_W-1:0] kind;
	logic [CODE_W-1:0] code_value;
	logic [SEL_W-1:0] bin_select;
	logic out_valid;
	logic out_ready;
	logic [SEL_W-1:0] bin_number;
	logic [OUT_W-1:0] bin_total;
	logic [OUT_W-1:0] dropped_total;

	// shadow histogram
	logic [OUT_W-1:0] shadow_bins [MAX_BINS_DEF];
	logic [OUT_W-1:0] shadow_below;
	logic [OUT_W-1:0] shadow_above;
	logic [OUT_W-1:0] shadow_center;
	logic [OUT_W-1:0] shadow_dropped;
	logic [CFG_W-1:0] shadow_bin_count;

	read_beat_t pending_reads[$];
	int error_count = 0;
	int cycle_count = 0;
	bit quiet = 1'b0;
	bit hold_off_req = 1'b0;

	// bin counts used per phase after the directed part, extremes included
	logic [CFG_W-1:0] phase_bin_counts [NUM_PHASES] = '{
		11'd4, 11'd2047, 11'd0, 11'd5, 11'd1023, 11'd3, 11'd1025, 11'd1024, 11'd6,
		11'd40, 11'd1
	};

	// reset values start at radius 512
	stim_row_t directed_rows [22] = '{
		'{KIND_READ, 16'd0, 10'd0, 1'b1, 32'd0, 32'd0},
		'{KIND_ADD, 16'd0, 10'd0, 1'b0, 32'd0, 32'd0},
		'{KIND_ADD, 16'd1023, 10'd0, 1'b0, 32'd0, 32'd0},
		'{KIND_ADD, 16'd511, 10'd0, 1'b0, 32'd0, 32'd0},
		'{KIND_ADD, 16'd512, 10'd0, 1'b0, 32'd0, 32'd0},
		'{KIND_ADD, 16'd513, 10'd0, 1'b0, 32'd0, 32'd0},
		'{KIND_ADD, 16'd1024, 10'd0, 1'b0, 32'd0, 32'd0},
		'{KIND_ADD, 16'hFFFF, 10'd0, 1'b0, 32'd0, 32'd0},
		'{KIND_UNUSED, 16'hFFFF, 10'h3FF, 1'b0, 32'd0, 32'd0},
		'{KIND_READ, 16'd0, 10'd0, 1'b0, 32'd0, 32'd0},
		'{KIND_READ, 16'd0, 10'd1023, 1'b0, 32'd0, 32'd0},
		'{KIND_READ, 16'd0, 10'd511, 1'b0, 32'd0, 32'd0},
		'{KIND_READ, 16'd0, 10'd512, 1'b0, 32'd0, 32'd0},
		'{KIND_READ, 16'd0, 10'd513, 1'b0, 32'd0, 32'd0},
		'{KIND_READ, 16'hFFFF, 10'd700, 1'b1, 32'd0, 32'd2},
		'{KIND_CLEAR, 16'd0, 10'd0, 1'b0, 32'd0, 32'd0},
		'{KIND_READ, 16'd0, 10'd512, 1'b1, 32'd0, 32'd0},
		'{KIND_ADD, 16'd512, 10'd0, 1'b0, 32'd0, 32'd0},
		'{KIND_ADD, 16'd512, 10'd0, 1'b0, 32'd0, 32'd0},
		'{KIND_ADD, 16'd1023, 10'd0, 1'b0, 32'd0, 32'd0},
		'{KIND_READ, 16'd0, 10'd512, 1'b0, 32'd0, 32'd0},
		'{KIND_READ, 16'd0, 10'd1023, 1'b0, 32'd0, 32'd0}
	};

	centered_sparse_histogram_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.code_value(code_value),
		.bin_select(bin_select),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.bin_number(bin_number),
		.bin_total(bin_total),
		.dropped_total(dropped_total)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// hard stop
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_PRINTS)
			$display("ERROR cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	function automatic logic [OUT_W-1:0] sat_inc(input logic [OUT_W-1:0] v);
		return (v == COUNT_TOP) ? v : v + 1'b1;
	endfunction

	function automatic logic [NUM_W-1:0] bins_in_use();
		if (shadow_bin_count < MIN_BINS)
			return NUM_W'(MIN_BINS);
		if (shadow_bin_count > MAX_BINS_DEF)
			return NUM_W'(MAX_BINS_DEF);
		return NUM_W'(shadow_bin_count);
	endfunction

	function automatic void clear_shadow();
		foreach (shadow_bins[i])
			shadow_bins[i] = '0;
		shadow_below = '0;
		shadow_above = '0;
		shadow_center = '0;
		shadow_dropped = '0;
	endfunction

	// apply one accepted beat to the shadow histogram; returns 1 when a read result follows
	function automatic bit histogram_step(input logic [KIND_W-1:0] k, input logic [CODE_W-1:0] c,
			input logic [SEL_W-1:0] s, output read_beat_t res);
		logic [NUM_W-1:0] n;
		logic [NUM_W-1:0] radius;
		logic [NUM_W-1:0] cw;
		logic [NUM_W-1:0] sw;
		n = bins_in_use();
		radius = n >> 1;
		cw = NUM_W'(c);
		sw = NUM_W'(s);
		res = '{bin: s, total: '0, dropped: '0};
		case (k)
			KIND_ADD: begin
				if (cw >= n)
					shadow_dropped = sat_inc(shadow_dropped);
				else if (cw == radius)
					shadow_center = sat_inc(shadow_center);
				else if (cw == radius - 1)
					shadow_below = sat_inc(shadow_below);
				else if (cw == radius + 1)
					shadow_above = sat_inc(shadow_above);
				else
					shadow_bins[c[SEL_W-1:0]] = sat_inc(shadow_bins[c[SEL_W-1:0]]);
				return 1'b0;
			end
			KIND_READ: begin
				if (sw < n) begin
					if (sw == radius)
						res.total = shadow_center;
					else if (sw == radius - 1)
						res.total = shadow_below;
					else if (sw == radius + 1)
						res.total = shadow_above;
					else
						res.total = shadow_bins[s];
				end
				res.dropped = shadow_dropped;
				return 1'b1;
			end
			KIND_CLEAR: begin
				clear_shadow();
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic int pick_idle();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// offer one beat, wait for acceptance, then optionally go idle
	task automatic send_beat(input logic [KIND_W-1:0] k, input logic [CODE_W-1:0] c,
			input logic [SEL_W-1:0] s, input bit fixed, input logic [OUT_W-1:0] t,
			input logic [OUT_W-1:0] d);
		read_beat_t res;
		int gap;
		in_valid <= 1'b1;
		kind <= k;
		code_value <= c;
		bin_select <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (histogram_step(k, c, s, res)) begin
			if (fixed) begin
				res.total = t;
				res.dropped = d;
			end
			pending_reads.push_back(res);
		end
		gap = pick_idle();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold the input until every read has returned and the back end has settled
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_bin_count(input logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_bin_count = v;
	endtask

	function automatic logic [CODE_W-1:0] near_center(input logic [NUM_W-1:0] radius);
		return CODE_W'(radius - 2 + $urandom_range(0, 4));
	endfunction

	task automatic random_phase(input int phase);
		logic [NUM_W-1:0] n;
		logic [NUM_W-1:0] radius;
		logic [CODE_W-1:0] c;
		logic [SEL_W-1:0] s;
		int r;
		int q;
		int done;
		n = bins_in_use();
		radius = n >> 1;
		done = 0;
		while (done < PHASE_ITEMS) begin
			r = $urandom_range(0, 99);
			q = $urandom_range(0, 99);
			c = CODE_W'($urandom);
			s = SEL_W'($urandom);
			if (r < 55) begin
				// add sample, mostly inside the bins in use
				if (q < 40)
					c = near_center(radius);
				else if (q < 80)
					c = CODE_W'($urandom_range(0, n - 1));
				else if (q < 90)
					c = CODE_W'(n + $urandom_range(0, 3));
				send_beat(KIND_ADD, c, s, 1'b0, '0, '0);
				done++;
			end else if (r < 87) begin
				// read back, mostly where counts live
				if (q < 40)
					s = SEL_W'(near_center(radius));
				else if (q < 80)
					s = SEL_W'($urandom_range(0, n - 1));
				send_beat(KIND_READ, c, s, 1'b0, '0, '0);
				done++;
			end else if (r < 89) begin
				send_beat(KIND_CLEAR, c, s, 1'b0, '0, '0);
				done++;
			end else begin
				// unused kind, ignored by the block
				send_beat(KIND_UNUSED, c, s, 1'b0, '0, '0);
			end
			if (done == PHASE_ITEMS / 2) begin
				if (phase == HOLD_PHASE)
					hold_off_req = 1'b1;
				if (phase == PAUSE_PHASE) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (pending_reads.size() != 0)
						@(posedge clk);
				end
			end
		end
		// close on a read so everything before it has passed the back end
		send_beat(KIND_READ, 16'd0, SEL_W'(radius), 1'b0, '0, '0);
	endtask

	// result side: check beats, idle at random, one long hold-off on request
	initial begin
		int stall;
		read_beat_t want;
		stall = 0;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_reads.size() == 0) begin
					report_mismatch($sformatf("unexpected result beat bin %0d", bin_number));
				end else begin
					want = pending_reads.pop_front();
					if (bin_number !== want.bin)
						report_mismatch($sformatf("bin_number %0d, want %0d",
							bin_number, want.bin));
					if (bin_total !== want.total)
						report_mismatch($sformatf("bin %0d: bin_total %0d, want %0d",
							want.bin, bin_total, want.total));
					if (dropped_total !== want.dropped)
						report_mismatch($sformatf("bin %0d: dropped_total %0d, want %0d",
							want.bin, dropped_total, want.dropped));
				end
			end
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				stall = pick_idle();
				out_ready <= (stall == 0);
			end
		end
	end

	// stimulus
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		kind <= KIND_ADD;
		code_value <= '0;
		bin_select <= '0;
		clear_shadow();
		shadow_bin_count = BIN_COUNT_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_beat(directed_rows[i].kind, directed_rows[i].code, directed_rows[i].sel,
				directed_rows[i].fixed, directed_rows[i].total, directed_rows[i].dropped);
		drain();

		// bins carry over from one setting to the next unless cleared
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_bin_count(phase_bin_counts[p]);
			quiet = (p == QUIET_PHASE);
			random_phase(p);
			drain();
		end

		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
